[sv/abc_pkg.sv]
`default_nettype none

package abc_pkg;

  // Largest span the block honors; larger span registers clip to it
  localparam int MAX_DIM = 4096;

  // Field and register widths
  localparam int PixW    = 32;
  localparam int ColorW  = 24;
  localparam int CoordW  = 15;
  localparam int OriginW = 12;
  localparam int SpanW   = 13;
  localparam int DimW    = SpanW + 1;
  localparam int CfgIdxW = 3;

  // Stream payload widths, padded to whole bytes
  localparam int InDataW  = 2 * PixW;
  localparam int OutBitsW = 2 * CoordW + ColorW;
  localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;
  localparam int OutPadW  = OutDataW - OutBitsW;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegOriginX  = 3'd0,
    RegOriginY  = 3'd1,
    RegAreaX    = 3'd2,
    RegAreaY    = 3'd3,
    RegPictureX = 3'd4,
    RegPictureY = 3'd5,
    RegCenter   = 3'd6
  } cfg_reg_t;

  // Clip a span register to MAX_DIM
  function automatic logic [DimW-1:0] lim_dim(input logic [SpanW-1:0] v);
    logic [DimW-1:0] wide;
    wide = {1'b0, v};
    return (wide > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : wide;
  endfunction

  // Blend one byte lane: ((a+1)*s + (256-a)*d) >> 8
  function automatic logic [7:0] lane_mix(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
    logic [8:0]  w_src;
    logic [8:0]  w_dst;
    logic [17:0] sum;
    w_src = {1'b0, a} + 9'd1;
    w_dst = 9'd256 - {1'b0, a};
    sum   = 18'(w_src) * 18'(s) + 18'(w_dst) * 18'(d);
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

[sv/abc_blend.sv]
`default_nettype none

module abc_blend
  import abc_pkg::*;
(
  input  wire logic [PixW-1:0]   src,
  input  wire logic [PixW-1:0]   dst,
  output logic      [ColorW-1:0] color
);

  logic [7:0] alpha;
  logic [7:0] lane0;
  logic [7:0] lane1;
  logic [7:0] lane2;

  // Blend the three color lanes with the source alpha
  always_comb begin
    alpha = src[31:24];
    lane0 = lane_mix(src[7:0],   dst[7:0],   alpha);
    lane1 = lane_mix(src[15:8],  dst[15:8],  alpha);
    lane2 = lane_mix(src[23:16], dst[23:16], alpha);
  end

  // Swap lanes 0 and 2, drop alpha
  assign color = {lane0, lane1, lane2};

endmodule

`default_nettype wire

[sv/alpha_blit_compositor.sv]
// Alpha-blits a source image over a framebuffer area. Pixels enter in raster order on
// s_axis, each with the framebuffer word found at its destination; the block counts
// column and row itself and wraps them at the picture spans. Pixels outside the clip
// region (picture size limited to area size, both capped at MAX_DIM) are consumed
// without a result; every other pixel leaves on m_axis with its destination
// coordinate, blended color and tlast on the last drawn pixel. One pixel is taken
// per clock while s_axis_tready is high; a result passes through an input stage
// register and then an output register before it is presented on m_axis. s_axis_tready
// falls only when both stages hold data and m_axis_tready is low. Write configuration
// only while no pixel is in flight.
`default_nettype none

module alpha_blit_compositor
  import abc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [SpanW-1:0]    cfg_data,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // s_axis_tdata: source_pixel[31:0], backdrop_pixel[63:32]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // m_axis_tdata: dest_x[14:0], dest_y[29:15], blended_color[53:30], zero pad[55:54]
  output logic      [OutDataW-1:0] m_axis_tdata,
  // m_axis_tlast: final_pixel
  output logic                     m_axis_tlast
);

  // Configuration registers
  logic [OriginW-1:0] area_origin_x;
  logic [OriginW-1:0] area_origin_y;
  logic [SpanW-1:0]   area_span_x;
  logic [SpanW-1:0]   area_span_y;
  logic [SpanW-1:0]   picture_span_x;
  logic [SpanW-1:0]   picture_span_y;
  logic               centering_on;

  // Position counters
  logic [SpanW-1:0] column_count;
  logic [SpanW-1:0] row_count;
  logic [SpanW-1:0] column_count_next;
  logic [SpanW-1:0] row_count_next;

  // Input stage
  logic             in_valid;
  logic [PixW-1:0]  in_src;
  logic [PixW-1:0]  in_dst;
  logic [SpanW-1:0] in_col;
  logic [SpanW-1:0] in_row;

  // Output stage
  logic                out_valid;
  logic [CoordW-1:0]   out_x;
  logic [CoordW-1:0]   out_y;
  logic [ColorW-1:0]   out_color;
  logic                out_last;

  // Derived geometry
  logic [DimW-1:0]   ax;
  logic [DimW-1:0]   ay;
  logic [DimW-1:0]   px;
  logic [DimW-1:0]   py;
  logic [DimW-1:0]   clip_x;
  logic [DimW-1:0]   clip_y;
  logic [CoordW-1:0] off_x;
  logic [CoordW-1:0] off_y;

  logic              accept;
  logic              out_free;
  logic              draw;
  logic [DimW-1:0]   col_inc;
  logic [DimW-1:0]   row_inc;
  logic [DimW-1:0]   in_col_inc;
  logic [DimW-1:0]   in_row_inc;
  logic [CoordW-1:0] dest_x;
  logic [CoordW-1:0] dest_y;
  logic              last_hit;
  logic [ColorW-1:0] color;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      area_origin_x  <= '0;
      area_origin_y  <= '0;
      area_span_x    <= '0;
      area_span_y    <= '0;
      picture_span_x <= '0;
      picture_span_y <= '0;
      centering_on   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegOriginX:  area_origin_x  <= cfg_data[OriginW-1:0];
        RegOriginY:  area_origin_y  <= cfg_data[OriginW-1:0];
        RegAreaX:    area_span_x    <= cfg_data;
        RegAreaY:    area_span_y    <= cfg_data;
        RegPictureX: picture_span_x <= cfg_data;
        RegPictureY: picture_span_y <= cfg_data;
        RegCenter:   centering_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clip spans and centering offsets
  always_comb begin
    ax     = lim_dim(area_span_x);
    ay     = lim_dim(area_span_y);
    px     = lim_dim(picture_span_x);
    py     = lim_dim(picture_span_y);
    clip_x = (px > ax) ? ax : px;
    clip_y = (py > ay) ? ay : py;
    if (centering_on) begin
      off_x = CoordW'(ax >> 1) - CoordW'(px >> 1);
      off_y = CoordW'(ay >> 1) - CoordW'(py >> 1);
    end else begin
      off_x = '0;
      off_y = '0;
    end
  end

  // Handshake: the input stage moves whenever the output register can take it
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Advance column and row, wrapping at the picture spans
  always_comb begin
    col_inc = {1'b0, column_count} + DimW'(1);
    row_inc = {1'b0, row_count} + DimW'(1);
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (col_inc >= px) begin
        column_count_next = '0;
        row_count_next    = (row_inc >= py) ? '0 : row_inc[SpanW-1:0];
      end else begin
        column_count_next = col_inc[SpanW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Capture the transfer with its position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_src <= s_axis_tdata[PixW-1:0];
      in_dst <= s_axis_tdata[InDataW-1:PixW];
      in_col <= column_count;
      in_row <= row_count;
    end
  end

  abc_blend u_blend (
    .src   (in_src),
    .dst   (in_dst),
    .color (color)
  );

  // Clip test, destination and last-pixel flag
  always_comb begin
    in_col_inc = {1'b0, in_col} + DimW'(1);
    in_row_inc = {1'b0, in_row} + DimW'(1);
    draw       = ({1'b0, in_col} < clip_x) && ({1'b0, in_row} < clip_y);
    last_hit   = (in_col_inc == clip_x) && (in_row_inc == clip_y);
    dest_x     = CoordW'(area_origin_x) + off_x + CoordW'(in_col);
    dest_y     = CoordW'(area_origin_y) + off_y + CoordW'(in_row);
  end

  // Load the result register; clipped pixels drop here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid && draw;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid && draw) begin
      out_x     <= dest_x;
      out_y     <= dest_y;
      out_color <= color;
      out_last  <= last_hit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_color, out_y, out_x};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

[sv/abc_checker.sv]
`default_nettype none

module abc_checker
  import abc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds its data and stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Padding above the color stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OutBitsW] == '0)
    else $error("padding bits set in result");

  // With the output empty the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // No result can appear without an earlier input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) ##1
    !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without input");

endmodule

bind alpha_blit_compositor abc_checker u_abc_checker (.*);

`default_nettype wire
